// ===== hw/rtl/epc_pkg.sv =====
// Shared types, knot tables and constants of the e-paper waveform temperature compensator.
package epc_pkg;

    localparam int TABLE_BYTES  = 159;
    localparam int PHASE_BYTES  = 153;
    localparam int PHASE_PERIOD = 7;
    localparam int KNOTS        = 8;
    localparam int MUL_W        = 18;

    typedef logic signed [11:0] t_temp;
    typedef logic signed [8:0]  t_coef;

    // Knot temperatures in 1/16 C steps: -10, 0, 10, 20, 25, 30, 40, 50 C
    localparam t_temp KNOT_T16 [KNOTS] = '{
        -12'sd160, 12'sd0, 12'sd160, 12'sd320, 12'sd400, 12'sd480, 12'sd640, 12'sd800
    };

    // Interval starting at this knot spans 5 C (80 steps) instead of 10 C
    localparam logic SHORT_SPAN [KNOTS] = '{
        1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0
    };

    localparam logic signed [13:0] SPAN_LONG  = 14'sd160;
    localparam logic signed [13:0] SPAN_SHORT = 14'sd80;

    // Extra-cycle window bounds, 15 C and 35 C
    localparam t_temp EXTRA_LOW_T16  = 12'sd240;
    localparam t_temp EXTRA_HIGH_T16 = 12'sd560;

    // Compensated quantities per knot
    typedef enum logic [1:0] {
        F_VCOM,
        F_GATE,
        F_MULT
    } t_field;

    localparam t_coef KNOT_COEF [3][KNOTS] = '{
        '{9'sd12, 9'sd8, 9'sd4, 9'sd2, 9'sd0, -9'sd2, -9'sd4, -9'sd8},
        '{9'sd8, 9'sd6, 9'sd3, 9'sd1, 9'sd0, -9'sd1, -9'sd3, -9'sd6},
        '{9'sd120, 9'sd110, 9'sd105, 9'sd102, 9'sd100, 9'sd98, 9'sd95, 9'sd90}
    };

    // Reciprocal multipliers: x/5 = (x*205)>>10 for x < 1024,
    // x/25 = (x*5243)>>17 for x < 43690
    localparam logic signed [MUL_W-1:0] RECIP5   = 18'sd205;
    localparam logic signed [MUL_W-1:0] RECIP25  = 18'sd5243;

    // How a byte is treated at its table position
    typedef enum logic [1:0] {
        CLS_VOLT,
        CLS_GATE_SCALE,
        CLS_TIMING,
        CLS_CTRL
    } t_cls;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LERP_MUL,
        S_LERP_DIV,
        S_LERP_ACC,
        S_APPLY,
        S_SCALE_DIV,
        S_SCALE_FIN,
        S_DONE
    } t_state;

    // Interpolation segment chosen from the temperature
    typedef struct packed {
        logic [2:0] lo;
        logic [7:0] n;
        logic       short_span;
        logic       clamp;
        logic       extra;
    } t_seg;

endpackage

// ===== hw/rtl/epc_if.sv =====
// Valid/ready channel interfaces for base bytes in and compensated bytes out.
interface epc_in_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] temperature;
    logic [7:0]         base_byte;

    modport source (output valid, output temperature, output base_byte, input ready);
    modport sink   (input valid, input temperature, input base_byte, output ready);
endinterface

interface epc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] comp_byte;
    logic       extra_refresh;
    logic       last;

    modport source (output valid, output comp_byte, output extra_refresh, output last,
                    input ready);
    modport sink   (input valid, input comp_byte, input extra_refresh, input last,
                    output ready);
endinterface

// ===== hw/rtl/epc_knot_sel.sv =====
// Finds the interpolation segment, offset within it, clamp and extra-cycle flag.
module epc_knot_sel import epc_pkg::*; (
    input  t_temp i_temp,
    output t_seg  o_seg
);

    logic [2:0]         w_lo;
    logic signed [11:0] w_diff;

    // lowest interval [lo, lo+1] holding the temperature: count knots 1 to KNOTS-2 strictly below
    always_comb begin
        w_lo = '0;
        for (int k = 1; k < KNOTS - 1; k++) begin
            if (KNOT_T16[k] < i_temp) begin
                w_lo = w_lo + 3'd1;
            end
        end
        w_diff = i_temp - KNOT_T16[w_lo];
    end

    // clamp at the table ends, n = 0 leaves the end entry as it stands
    always_comb begin
        o_seg.extra      = (i_temp < EXTRA_LOW_T16) || (i_temp > EXTRA_HIGH_T16);
        o_seg.short_span = SHORT_SPAN[w_lo];
        if (i_temp <= KNOT_T16[0]) begin
            o_seg.lo    = '0;
            o_seg.n     = '0;
            o_seg.clamp = 1'b1;
        end else if (i_temp >= KNOT_T16[KNOTS-1]) begin
            o_seg.lo    = 3'(KNOTS - 1);
            o_seg.n     = '0;
            o_seg.clamp = 1'b1;
        end else begin
            o_seg.lo    = w_lo;
            o_seg.n     = w_diff[7:0];
            o_seg.clamp = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/epc_mul.sv =====
// Shared signed multiplier with registered product.
module epc_mul import epc_pkg::*; (
    input  logic                        i_clk,
    input  logic signed [MUL_W-1:0]     i_a,
    input  logic signed [MUL_W-1:0]     i_b,
    output logic signed [2*MUL_W-1:0]   o_p
);

    logic signed [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/epaper_lut_temp_compensator_top.sv =====
// Top level: sequencer around one shared multiplier compensating waveform bytes.
// Each byte runs three interpolation passes (multiply, divide, accumulate) on the shared
// multiplier, then one apply step; offset and pass-through bytes end there, and scaled
// gate bytes add two reciprocal-divide steps. A new byte is accepted only after the
// previous result has been loaded into the output register.
// Synchronous active-low reset returns to idle, clears the table position and output valid.
module epaper_lut_temp_compensator_top import epc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    epc_in_if.sink   i_in,
    epc_out_if.source o_out
);

    t_state r_state, n_state;
    t_seg   w_seg, r_seg;

    logic [7:0] r_pos;
    logic [2:0] r_mod7;
    logic [7:0] r_byte;
    t_cls       r_cls, w_cls;
    logic       r_last, r_extra;
    t_field     r_fld, n_fld;
    t_coef      r_val [3];
    logic       r_neg;
    logic [7:0] r_res, n_res;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_extra, r_out_last;

    logic                      w_in_acc, w_load;
    logic signed [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic signed [2*MUL_W-1:0] w_prod;

    t_coef              w_coef_a, w_coef_b, w_off;
    logic signed [9:0]  w_delta;
    logic signed [10:0] w_two_d;
    logic signed [13:0] w_num;
    logic [12:0]        w_mag;
    logic [7:0]         w_mag_sh;
    logic [4:0]         w_q;
    logic signed [9:0]  w_lerp;
    logic signed [9:0]  w_sum;
    logic [7:0]         w_sat;
    logic [12:0]        w_scaled_q4;
    logic [8:0]         w_scaled;

    epc_knot_sel u_knot_sel (
        .i_temp (i_in.temperature),
        .o_seg  (w_seg)
    );

    epc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // byte class from table position
    always_comb begin
        if (r_pos < 8'(PHASE_BYTES)) begin
            if (r_mod7 == 3'd0) begin
                w_cls = CLS_VOLT;
            end else if (r_mod7 <= 3'd2) begin
                w_cls = CLS_GATE_SCALE;
            end else begin
                w_cls = CLS_TIMING;
            end
        end else if (r_pos < 8'(TABLE_BYTES - 1)) begin
            w_cls = CLS_CTRL;
        end else begin
            w_cls = CLS_VOLT;
        end
    end

    // interpolation arithmetic: a + trunc((2*d*n + den) / (2*den))
    always_comb begin
        w_coef_a = KNOT_COEF[r_fld][r_seg.lo];
        w_coef_b = r_seg.clamp ? w_coef_a : KNOT_COEF[r_fld][3'(r_seg.lo + 3'd1)];
        w_delta  = 10'(w_coef_b) - 10'(w_coef_a);
        w_two_d  = {w_delta, 1'b0};
        w_num    = $signed(w_prod[13:0]) + (r_seg.short_span ? SPAN_SHORT : SPAN_LONG);
        w_mag    = w_num[13] ? 13'(-w_num) : w_num[12:0];
        // 2*den is 5*32 or 5*64: shift first, then divide by five
        w_mag_sh = r_seg.short_span ? 8'(w_mag >> 5) : 8'(w_mag >> 6);
        w_q      = w_prod[14:10];
        w_lerp   = r_neg ? 10'(w_coef_a) - $signed({5'd0, w_q})
                         : 10'(w_coef_a) + $signed({5'd0, w_q});
    end

    // byte offset, saturation, and percent scale
    always_comb begin
        w_off = (r_cls == CLS_VOLT) ? r_val[F_VCOM] : r_val[F_GATE];
        w_sum = $signed({2'b00, r_byte}) + 10'(w_off);
        if (w_sum < 0) begin
            w_sat = 8'd0;
        end else if (w_sum > 10'sd255) begin
            w_sat = 8'd255;
        end else begin
            w_sat = w_sum[7:0];
        end
        // divide by 100 as (x/4)/25
        w_scaled_q4 = w_prod[14:2];
        w_scaled    = w_prod[25:17];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in.valid) n_state = S_LERP_MUL;
            S_LERP_MUL:  n_state = S_LERP_DIV;
            S_LERP_DIV:  n_state = S_LERP_ACC;
            S_LERP_ACC:  n_state = (r_fld == F_MULT) ? S_APPLY : S_LERP_MUL;
            S_APPLY:     n_state = (r_cls == CLS_GATE_SCALE) ? S_SCALE_DIV : S_DONE;
            S_SCALE_DIV: n_state = S_SCALE_FIN;
            S_SCALE_FIN: n_state = S_DONE;
            S_DONE:      if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // multiplier operands, field step and result per state
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        n_fld   = r_fld;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                n_fld = F_VCOM;
            end
            S_LERP_MUL: begin
                w_mul_a = MUL_W'(w_two_d);
                w_mul_b = {10'd0, r_seg.n};
            end
            S_LERP_DIV: begin
                w_mul_a = {10'd0, w_mag_sh};
                w_mul_b = RECIP5;
            end
            S_LERP_ACC: begin
                unique case (r_fld)
                    F_VCOM:  n_fld = F_GATE;
                    F_GATE:  n_fld = F_MULT;
                    default: n_fld = F_VCOM;
                endcase
            end
            S_APPLY: begin
                w_mul_a = {10'd0, w_sat};
                w_mul_b = MUL_W'(r_val[F_MULT]);
                n_res   = (r_cls == CLS_TIMING) ? r_byte : w_sat;
            end
            S_SCALE_DIV: begin
                w_mul_a = {5'd0, w_scaled_q4};
                w_mul_b = RECIP25;
            end
            S_SCALE_FIN: begin
                n_res = w_scaled[8] ? 8'd255 : w_scaled[7:0];
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_mod7      <= '0;
            r_fld       <= F_VCOM;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fld   <= n_fld;
            if (w_in_acc) begin
                if (r_pos == 8'(TABLE_BYTES - 1)) begin
                    r_pos  <= '0;
                    r_mod7 <= '0;
                end else begin
                    r_pos  <= r_pos + 8'd1;
                    r_mod7 <= (r_mod7 == 3'(PHASE_PERIOD - 1)) ? 3'd0 : r_mod7 + 3'd1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_in_acc) begin
            r_seg   <= w_seg;
            r_byte  <= i_in.base_byte;
            r_cls   <= w_cls;
            r_last  <= (r_pos == 8'(TABLE_BYTES - 1));
            r_extra <= w_seg.extra;
        end
        if (r_state == S_LERP_DIV) begin
            r_neg <= w_num[13];
        end
        if (r_state == S_LERP_ACC) begin
            r_val[r_fld] <= w_lerp[8:0];
        end
        if (w_load) begin
            r_out_byte  <= r_res;
            r_out_extra <= r_extra;
            r_out_last  <= r_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.comp_byte     = r_out_byte;
    assign o_out.extra_refresh = r_out_extra;
    assign o_out.last          = r_out_last;

endmodule

// ===== hw/rtl/epc_checker.sv =====
// Port-level assertions for the compensator top level, with its bind statement.
module epc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_extra,
    input logic       i_out_last
);

    // a stalled output transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_extra) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    // one byte in work at a time: input ready stays low after an accepted byte
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("input accepted while a byte is in work");

    // no result appears right after an input transaction
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // reset leaves an empty output and an idle input side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("reset state wrong");

endmodule

bind epaper_lut_temp_compensator_top epc_checker u_epc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.comp_byte),
    .i_out_extra (o_out.extra_refresh),
    .i_out_last  (o_out.last)
);

// ===== sim/tb.sv =====
// Testbench for the e-paper waveform temperature compensator: directed table, then random stream.
`timescale 1ns / 100ps

module tb import epc_pkg::*; ();

    localparam int  CYCLE_LIMIT = 400_000;
    localparam int  RAND_ITEMS  = 1700;
    localparam int  PAUSE_EVERY = 425;
    localparam int  SETTLE_CYC  = 40;
    localparam int  MAX_REPORTS = 10;
    localparam int  BYTE_MAX    = 255;
    localparam int  SCALE_PCT   = 100;
    localparam int  EXTRA_LO_C  = 15;
    localparam int  EXTRA_HI_C  = 35;
    localparam int  NKNOT       = 8;
    localparam int  DIR_N       = 25;

    // Compensation knots: temperature in C, vcom, gate, multiplier percent, extra flag
    localparam int KNOT_C    [NKNOT] = '{-10, 0, 10, 20, 25, 30, 40, 50};
    localparam int KNOT_VCOM [NKNOT] = '{12, 8, 4, 2, 0, -2, -4, -8};
    localparam int KNOT_GATE [NKNOT] = '{8, 6, 3, 1, 0, -1, -3, -6};
    localparam int KNOT_MULT [NKNOT] = '{120, 110, 105, 102, 100, 98, 95, 90};
    localparam bit KNOT_XTRA [NKNOT] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

    typedef struct packed {
        logic [7:0] comp_byte;
        logic       extra_refresh;
        logic       last;
    } wf_result_t;

    // Directed row: either a hand-computed expectation or one taken from the predictor
    localparam logic EXP_FIXED = 1'b1;
    localparam logic EXP_MODEL = 1'b0;

    typedef struct packed {
        logic signed [11:0] temp;
        logic [7:0]         base;
        logic               src;
        wf_result_t         exp;
    } dir_row_t;

    // Rows start at table position 0 right after reset
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{12'h800,      8'd250,  EXP_FIXED, '{8'd255, 1'b1, 1'b0}}, // volt, low clamp, saturate up
        '{12'sd2047,    8'd0,    EXP_FIXED, '{8'd0,   1'b1, 1'b0}}, // gate, high clamp, floor
        '{-12'sd160,    8'd255,  EXP_FIXED, '{8'd255, 1'b1, 1'b0}}, // gate, scale saturates
        '{12'sd0,       8'hAA,   EXP_FIXED, '{8'hAA,  1'b1, 1'b0}}, // timing passes
        '{12'sd800,     8'h55,   EXP_FIXED, '{8'h55,  1'b1, 1'b0}}, // exact high knot clamps
        '{12'sd240,     8'd0,    EXP_FIXED, '{8'd0,   1'b0, 1'b0}}, // extra window low edge
        '{12'sd560,     8'd255,  EXP_FIXED, '{8'd255, 1'b0, 1'b0}}, // extra window high edge
        '{12'sd800,     8'd3,    EXP_FIXED, '{8'd0,   1'b1, 1'b0}}, // volt saturates down
        '{12'sd400,     8'd200,  EXP_MODEL, '{8'd0,   1'b0, 1'b0}}, // 25 C knot, from below
        '{12'sd561,     8'd255,  EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{-12'sd1,      8'h0F,   EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{12'sd239,     8'hF0,   EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{12'sd1,       8'd1,    EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{-12'sd2047,   8'd254,  EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{12'h800,      8'd0,    EXP_FIXED, '{8'd12,  1'b1, 1'b0}}, // volt from zero
        '{12'h800,      8'd100,  EXP_FIXED, '{8'd129, 1'b1, 1'b0}}, // gate scale truncates
        '{12'sd2047,    8'd255,  EXP_FIXED, '{8'd224, 1'b1, 1'b0}}, // gate scale below 100 pct
        '{-12'sd100,    8'h3C,   EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{12'sd399,     8'h81,   EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{12'sd401,     8'h7E,   EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{-12'sd159,    8'hC3,   EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{12'sd799,     8'd0,    EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{-12'sd159,    8'd250,  EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{12'sd81,      8'd128,  EXP_MODEL, '{8'd0,   1'b0, 1'b0}},
        '{12'sd720,     8'd77,   EXP_MODEL, '{8'd0,   1'b0, 1'b0}}
    };

    logic i_clk;
    logic i_rst_n;

    epc_in_if  in_ch ();
    epc_out_if out_ch ();

    epaper_lut_temp_compensator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    wf_result_t byte_q[$];
    int         tbl_pos;
    int         cyc_cnt   = 0;
    int         n_err     = 0;
    int         n_sent;
    int         n_checked = 0;
    int         n_tables  = 0;
    int         n_pauses;
    int         rx_mode   = 0;
    int         rx_left   = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // a + trunc((b-a)*n/den + 1/2), exact, truncating toward zero
    function automatic int lerp_half_up(input int a, input int b, input int n, input int den);
        int num;
        num = 2 * (b - a) * n + den;
        return a + num / (2 * den);
    endfunction

    function automatic int clip_u8(input int v);
        if (v < 0) return 0;
        if (v > BYTE_MAX) return BYTE_MAX;
        return v;
    endfunction

    // Expected output for one base byte at table position pos
    function automatic wf_result_t compensate_byte(input logic signed [11:0] temp,
                                                   input logic [7:0] base, input int pos);
        int         t16;
        int         v;
        int         seg;
        int         n;
        int         den;
        int         vcom;
        int         gate;
        int         mult;
        bit         extra;
        t_cls       cls;
        wf_result_t r;
        t16 = temp;
        v   = base;
        seg = 0;
        if (t16 <= KNOT_C[0] * 16 || t16 >= KNOT_C[NKNOT-1] * 16) begin
            // clamped at either end, flag taken from the end knot
            seg   = (t16 <= KNOT_C[0] * 16) ? 0 : NKNOT - 1;
            vcom  = KNOT_VCOM[seg];
            gate  = KNOT_GATE[seg];
            mult  = KNOT_MULT[seg];
            extra = KNOT_XTRA[seg];
        end else begin
            // lowest interval holding t wins on a shared knot
            for (int k = NKNOT - 2; k >= 0; k--) begin
                if (t16 >= KNOT_C[k] * 16 && t16 <= KNOT_C[k+1] * 16) seg = k;
            end
            n     = t16 - KNOT_C[seg] * 16;
            den   = (KNOT_C[seg+1] - KNOT_C[seg]) * 16;
            vcom  = lerp_half_up(KNOT_VCOM[seg], KNOT_VCOM[seg+1], n, den);
            gate  = lerp_half_up(KNOT_GATE[seg], KNOT_GATE[seg+1], n, den);
            mult  = lerp_half_up(KNOT_MULT[seg], KNOT_MULT[seg+1], n, den);
            extra = (t16 < EXTRA_LO_C * 16) || (t16 > EXTRA_HI_C * 16);
        end

        // byte role by position; the final byte takes vcom like a voltage byte
        if (pos >= TABLE_BYTES - 1)              cls = CLS_VOLT;
        else if (pos >= PHASE_BYTES)             cls = CLS_CTRL;
        else if (pos % PHASE_PERIOD == 0)        cls = CLS_VOLT;
        else if (pos % PHASE_PERIOD <= 2)        cls = CLS_GATE_SCALE;
        else                                     cls = CLS_TIMING;

        case (cls)
            CLS_VOLT: v = clip_u8(v + vcom);
            CLS_GATE_SCALE: begin
                v = clip_u8(v + gate);
                v = v * mult / SCALE_PCT;
                if (v > BYTE_MAX) v = BYTE_MAX;
            end
            CLS_CTRL: v = clip_u8(v + gate);
            default: ;
        endcase

        r.comp_byte     = v[7:0];
        r.extra_refresh = extra;
        r.last          = (pos == TABLE_BYTES - 1);
        return r;
    endfunction

    // Drive one byte, hold until the transaction completes, then log its expectation
    task automatic send_byte(input logic signed [11:0] temp, input logic [7:0] base,
                             input logic src, input wf_result_t fixed);
        wf_result_t r;
        in_ch.valid       <= 1'b1;
        in_ch.temperature <= temp;
        in_ch.base_byte   <= base;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        r       = compensate_byte(temp, base, tbl_pos);
        tbl_pos = (tbl_pos == TABLE_BYTES - 1) ? 0 : tbl_pos + 1;
        byte_q.push_back(src == EXP_FIXED ? fixed : r);
        n_sent++;
    endtask

    // Drop valid and hold off until every outstanding byte has come back
    task automatic wait_drained;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (byte_q.size() != 0) @(posedge i_clk);
    endtask

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes outstanding", cyc_cnt,
                     byte_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Output ready: random modes (always, mostly, periodic, rare), each held until rx_left runs out
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(50, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= (cyc_cnt % 9 > 3);
            default: out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Output check against the oldest expectation
    always @(posedge i_clk) begin
        wf_result_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (byte_q.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("[%0d] unexpected output byte=%02h extra=%b last=%b", cyc_cnt,
                             out_ch.comp_byte, out_ch.extra_refresh, out_ch.last);
            end else begin
                e = byte_q.pop_front();
                n_checked++;
                if (out_ch.last === 1'b1) n_tables++;
                if (out_ch.comp_byte !== e.comp_byte ||
                    out_ch.extra_refresh !== e.extra_refresh ||
                    out_ch.last !== e.last) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display({"[%0d] mismatch: exp byte=%02h extra=%b last=%b, ",
                                  "got byte=%02h extra=%b last=%b"},
                                 cyc_cnt, e.comp_byte, e.extra_refresh, e.last,
                                 out_ch.comp_byte, out_ch.extra_refresh, out_ch.last);
                end
            end
        end
    end

    // Stimulus
    initial begin
        int                 burst_left;
        int                 gap;
        int                 t_int;
        logic signed [11:0] t_rand;
        logic [7:0]         b_rand;
        n_sent            = 0;
        n_pauses          = 0;
        tbl_pos           = 0;
        burst_left        = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.temperature <= '0;
        in_ch.base_byte   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows
        for (int i = 0; i < DIR_N; i++)
            send_byte(DIR_ROWS[i].temp, DIR_ROWS[i].base, DIR_ROWS[i].src, DIR_ROWS[i].exp);
        wait_drained();
        n_pauses++;

        // Random stream in bursts
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i != 0 && i % PAUSE_EVERY == 0) begin
                wait_drained();
                n_pauses++;
            end
            if (burst_left == 0) begin
                gap = $urandom_range(0, 12);
                if (gap != 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
            end
            burst_left--;

            // temperature: full range, interior, near knots, near flag edges, extremes
            case ($urandom_range(0, 9))
                0, 1:          t_int = $urandom_range(0, 4095);
                2, 3, 4, 5, 6: t_int = int'($urandom_range(0, 960)) - 160;
                7:             t_int = KNOT_C[$urandom_range(0, NKNOT - 1)] * 16
                                       + int'($urandom_range(0, 6)) - 3;
                8:             t_int = ($urandom_range(0, 1) ? EXTRA_LO_C : EXTRA_HI_C) * 16
                                       + int'($urandom_range(0, 4)) - 2;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       t_int = -2048;
                        1:       t_int = 2047;
                        2:       t_int = -160;
                        default: t_int = 800;
                    endcase
                end
            endcase
            t_rand = t_int[11:0];

            case ($urandom_range(0, 7))
                0:       b_rand = 8'd0;
                1:       b_rand = 8'd255;
                2:       b_rand = 8'($urandom_range(0, 15));
                3:       b_rand = 8'($urandom_range(240, 255));
                default: b_rand = 8'($urandom_range(0, 255));
            endcase

            send_byte(t_rand, b_rand, EXP_MODEL, '0);
        end

        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Run covered %0d input bytes and %0d checked outputs over %0d cycles.",
                 n_sent, n_checked, cyc_cnt);
        $display("Full tables completed: %0d; drain pauses: %0d; failures: %0d.",
                 n_tables, n_pauses, n_err);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
